// ----- rtl/wmor_pkg.sv -----
// Package for the windowed mean with outlier rejection block.
// Holds the window depth, derived widths, beat types and register indexes.
// Has no dependencies; every rtl file refers to it by scoped names.
package wmor_pkg;

  localparam int WIN_DEPTH  = 16;
  localparam int IDX_W      = $clog2(WIN_DEPTH);
  localparam int CNT_W      = $clog2(WIN_DEPTH + 1);
  localparam int SUM_W      = 16 + $clog2(WIN_DEPTH);
  localparam int DIV_STEP_W = $clog2(SUM_W);

  localparam logic [DIV_STEP_W-1:0] DIV_LAST = DIV_STEP_W'(SUM_W - 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_SQ = 1'b1;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] mean_x;
    logic signed [15:0] mean_y;
    logic signed [15:0] mean_z;
    logic [4:0]         inlier_count;
    logic               valid_res;
  } out_beat_t;

  typedef logic [2:0][SUM_W-1:0] sum3_t;
  typedef logic [2:0][15:0]      coord3_t;

endpackage

// ----- rtl/wmor_window.sv -----
// Point window store: a shift line of the most recent points, entry 0 newest.
// Every entry resets to zero; one entry is read at a time by index.
// Depends on wmor_pkg.
module wmor_window (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  wmor_pkg::in_beat_t         shift_pt,
  input  logic [wmor_pkg::IDX_W-1:0] rd_idx,
  output wmor_pkg::in_beat_t         rd_pt
);

  wmor_pkg::in_beat_t win_r [wmor_pkg::WIN_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wmor_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift_en) begin
      for (int i = wmor_pkg::WIN_DEPTH - 1; i > 0; i--) begin
        win_r[i] <= win_r[i-1];
      end
      win_r[0] <= shift_pt;
    end
  end

  assign rd_pt = win_r[rd_idx];

endmodule

// ----- rtl/wmor_div.sv -----
// Three-lane restoring divider: signed sums over a small unsigned divisor.
// One quotient bit per lane per cycle, truncating toward zero.
// Depends on wmor_pkg.
module wmor_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wmor_pkg::CNT_W-1:0] divisor,
  input  wmor_pkg::sum3_t            dividend,
  output logic                       done,
  output wmor_pkg::coord3_t          quot
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [wmor_pkg::DIV_STEP_W-1:0]     step_r, step_nxt;
  logic [wmor_pkg::CNT_W-1:0]          div_r, div_nxt;
  logic [2:0][wmor_pkg::SUM_W-1:0]     a_r, a_nxt;
  logic [2:0][wmor_pkg::CNT_W-1:0]     rem_r, rem_nxt;
  logic [2:0]                          neg_r, neg_nxt;
  logic [2:0][wmor_pkg::CNT_W:0]       trial;
  logic [2:0][wmor_pkg::CNT_W:0]       diff;
  logic [2:0][wmor_pkg::SUM_W-1:0]     q_full;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    div_nxt  = div_r;
    a_nxt    = a_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    for (int l = 0; l < 3; l++) begin
      trial[l] = {rem_r[l], a_r[l][wmor_pkg::SUM_W-1]};
      diff[l]  = trial[l] - {1'b0, div_r};
    end
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      div_nxt  = divisor;
      for (int l = 0; l < 3; l++) begin
        neg_nxt[l] = dividend[l][wmor_pkg::SUM_W-1];
        a_nxt[l]   = neg_nxt[l] ? ('0 - dividend[l]) : dividend[l];
        rem_nxt[l] = '0;
      end
    end else if (busy_r) begin
      for (int l = 0; l < 3; l++) begin
        if (trial[l] >= {1'b0, div_r}) begin
          rem_nxt[l] = diff[l][wmor_pkg::CNT_W-1:0];
          a_nxt[l]   = {a_r[l][wmor_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = trial[l][wmor_pkg::CNT_W-1:0];
          a_nxt[l]   = {a_r[l][wmor_pkg::SUM_W-2:0], 1'b0};
        end
      end
      step_nxt = step_r + {{(wmor_pkg::DIV_STEP_W-1){1'b0}}, 1'b1};
      if (step_r == wmor_pkg::DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    div_r <= div_nxt;
    a_r   <= a_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      q_full[l] = neg_r[l] ? ('0 - a_r[l]) : a_r[l];
      quot[l]   = q_full[l][15:0];
    end
  end

  assign done = done_r;

  a_start_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> divisor != '0)
    else $error("divider started with a zero divisor");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider finished without a run");

endmodule

// ----- rtl/window_mean_outlier_reject_3d_top.sv -----
// Windowed 3D point mean with outlier rejection.
// Input beats carry one Q3.12 point; each gives one output beat with the mean of
// the window points whose squared distance to the window mean is below the threshold, and their count.
// The config port (cfg_valid/cfg_ready, cfg_index, cfg_data) writes window_size
// (index 0) and outlier_threshold_sq (index 1); cfg_ready is always high. The user must
// make writes only while the block is idle; the block itself does not enforce this.
// An item runs in steps: one pass over the effective window of n points sums it, a divide
// gives the mean, a second pass runs each point's squared distance through one shared
// 17x17 multiplier in x, y, z and compare phases, and a second divide gives the inlier
// mean. When no point is an inlier the second divide is skipped.
// in_stall is high from acceptance until the result is loaded into the output register.
// The output register holds a result while out_stall is high, and a new point is taken
// meanwhile; a finished result then waits for the register to empty.
// Synchronous reset clears the window to zeros, restores window_size = 16 and
// outlier_threshold_sq = 2^24, and empties the output register.
// Depends on wmor_pkg, wmor_window and wmor_div.
module window_mean_outlier_reject_3d_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wmor_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wmor_pkg::out_beat_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wmor_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wmor_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SUM  = 6'b000010,
    ST_MDIV = 6'b000100,
    ST_DIST = 6'b001000,
    ST_IDIV = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    PH_X   = 2'd0,
    PH_Y   = 2'd1,
    PH_Z   = 2'd2,
    PH_CMP = 2'd3
  } phase_t;

  state_t                          state_r, state_nxt;
  phase_t                          ph_r, ph_nxt;
  logic [4:0]                      window_size_r;
  logic [31:0]                     thr_r;
  logic [wmor_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [wmor_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  wmor_pkg::sum3_t                 s_r, s_nxt;
  wmor_pkg::sum3_t                 i_r, i_nxt;
  wmor_pkg::coord3_t               mean_r, mean_nxt;
  logic [31:0]                     sq_r, sq_nxt;
  logic [32:0]                     acc_r, acc_nxt;
  logic                            div_start_r, div_start_nxt;
  logic                            out_valid_r, out_valid_nxt;
  wmor_pkg::out_beat_t             out_data_r, out_data_nxt;

  logic                            in_acc;
  wmor_pkg::in_beat_t              rd_pt;
  wmor_pkg::coord3_t               rd_c;
  logic [31:0]                     ws_ext, n32, idx_ext, cnt_ext32;
  logic [wmor_pkg::CNT_W-1:0]      n_cur;
  logic                            last_ent;
  logic signed [15:0]              c_pt, c_mean;
  logic signed [16:0]              diff;
  logic signed [33:0]              prod;
  logic [33:0]                     dist_sq;
  logic                            inlier;
  logic [wmor_pkg::CNT_W-1:0]      div_divisor;
  wmor_pkg::sum3_t                 div_dividend;
  logic                            div_done;
  wmor_pkg::coord3_t               quot;
  logic [wmor_pkg::CNT_W+4:0]      cnt_wide;

  wmor_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (in_acc),
    .shift_pt (in_data),
    .rd_idx   (idx_r),
    .rd_pt    (rd_pt)
  );

  wmor_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .divisor  (div_divisor),
    .dividend (div_dividend),
    .done     (div_done),
    .quot     (quot)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ws_ext   = {27'b0, window_size_r};
  assign n32      = (ws_ext == 32'd0) ? 32'd1 :
                    (ws_ext > 32'(wmor_pkg::WIN_DEPTH)) ? 32'(wmor_pkg::WIN_DEPTH) : ws_ext;
  assign n_cur    = n32[wmor_pkg::CNT_W-1:0];
  assign idx_ext  = {{(32-wmor_pkg::IDX_W){1'b0}}, idx_r};
  assign cnt_ext32 = {{(32-wmor_pkg::CNT_W){1'b0}}, cnt_r};
  assign last_ent = (idx_ext + 32'd1 == n32);
  assign cnt_wide = {5'b0, cnt_r};

  assign rd_c[0] = rd_pt.point_x;
  assign rd_c[1] = rd_pt.point_y;
  assign rd_c[2] = rd_pt.point_z;

  always_comb begin
    unique case (ph_r)
      PH_X: begin
        c_pt   = rd_c[0];
        c_mean = mean_r[0];
      end
      PH_Y: begin
        c_pt   = rd_c[1];
        c_mean = mean_r[1];
      end
      PH_Z, PH_CMP: begin
        c_pt   = rd_c[2];
        c_mean = mean_r[2];
      end
      default: begin
        c_pt   = rd_c[2];
        c_mean = mean_r[2];
      end
    endcase
  end

  assign diff    = {c_pt[15], c_pt} - {c_mean[15], c_mean};
  assign prod    = diff * diff;
  assign dist_sq = {1'b0, acc_r} + {2'b0, sq_r};
  assign inlier  = (dist_sq < {2'b0, thr_r});

  assign div_divisor  = (state_r == ST_MDIV) ? n_cur : cnt_r;
  assign div_dividend = (state_r == ST_MDIV) ? s_r : i_r;

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    s_nxt         = s_r;
    i_nxt         = i_r;
    mean_nxt      = mean_r;
    sq_nxt        = sq_r;
    acc_nxt       = acc_r;
    div_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SUM;
          idx_nxt   = '0;
          s_nxt     = '0;
        end
      end
      ST_SUM: begin
        for (int c = 0; c < 3; c++) begin
          s_nxt[c] = s_r[c] + {{(wmor_pkg::SUM_W-16){rd_c[c][15]}}, rd_c[c]};
        end
        idx_nxt = idx_r + {{(wmor_pkg::IDX_W-1){1'b0}}, 1'b1};
        if (last_ent) begin
          state_nxt     = ST_MDIV;
          div_start_nxt = 1'b1;
        end
      end
      ST_MDIV: begin
        if (div_done) begin
          mean_nxt  = quot;
          state_nxt = ST_DIST;
          ph_nxt    = PH_X;
          idx_nxt   = '0;
          cnt_nxt   = '0;
          i_nxt     = '0;
        end
      end
      ST_DIST: begin
        unique case (ph_r)
          PH_X: begin
            sq_nxt = prod[31:0];
            ph_nxt = PH_Y;
          end
          PH_Y: begin
            acc_nxt = {1'b0, sq_r};
            sq_nxt  = prod[31:0];
            ph_nxt  = PH_Z;
          end
          PH_Z: begin
            acc_nxt = acc_r + {1'b0, sq_r};
            sq_nxt  = prod[31:0];
            ph_nxt  = PH_CMP;
          end
          PH_CMP: begin
            if (inlier) begin
              for (int c = 0; c < 3; c++) begin
                i_nxt[c] = i_r[c] + {{(wmor_pkg::SUM_W-16){rd_c[c][15]}}, rd_c[c]};
              end
              cnt_nxt = cnt_r + {{(wmor_pkg::CNT_W-1){1'b0}}, 1'b1};
            end
            ph_nxt  = PH_X;
            idx_nxt = idx_r + {{(wmor_pkg::IDX_W-1){1'b0}}, 1'b1};
            if (last_ent) begin
              if (cnt_nxt == '0) begin
                state_nxt = ST_OUT;
              end else begin
                state_nxt     = ST_IDIV;
                div_start_nxt = 1'b1;
              end
            end
          end
          default: begin
            ph_nxt = PH_X;
          end
        endcase
      end
      ST_IDIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.inlier_count = cnt_wide[4:0];
          out_data_nxt.valid_res    = (cnt_r != '0);
          if (cnt_r == '0) begin
            out_data_nxt.mean_x = '0;
            out_data_nxt.mean_y = '0;
            out_data_nxt.mean_z = '0;
          end else begin
            out_data_nxt.mean_x = quot[0];
            out_data_nxt.mean_y = quot[1];
            out_data_nxt.mean_z = quot[2];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ph_r          <= PH_X;
      idx_r         <= '0;
      cnt_r         <= '0;
      div_start_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      window_size_r <= 5'd16;
      thr_r         <= 32'd16777216;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          wmor_pkg::CFG_WINDOW_SIZE:  window_size_r <= cfg_data[4:0];
          wmor_pkg::CFG_THRESHOLD_SQ: thr_r         <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    s_r        <= s_nxt;
    i_r        <= i_nxt;
    mean_r     <= mean_nxt;
    sq_r       <= sq_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("output register loaded outside the output step");

  a_no_inlier_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.valid_res |->
      out_data_r.mean_x == '0 && out_data_r.mean_y == '0 &&
      out_data_r.mean_z == '0 && out_data_r.inlier_count == '0)
    else $error("result without inliers carries a nonzero mean or count");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIST |-> cnt_ext32 <= idx_ext)
    else $error("inlier count exceeds points examined");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_SUM && idx_r == '0)
    else $error("accepted point did not start the summing pass");

endmodule
